// ===== design/apdt_pkg.sv =====
// ----------------------------------------------------------------------------
// ATA PIO drive target package
// Shared types and constants: operation codes, task-file register map,
// command codes, status values and the item and result records.
// ----------------------------------------------------------------------------
`default_nettype none

package apdt_pkg;

  // Kind of work carried by one input transaction.
  typedef enum logic [1:0] {
    OP_BUS   = 2'd0,
    OP_FILL  = 2'd1,
    OP_DRAIN = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  // Where the host read value of a bus sample comes from.
  typedef enum logic [1:0] {
    LRV_KEEP   = 2'd0,
    LRV_MEM    = 2'd1,
    LRV_STATUS = 2'd2
  } lrv_e;

  // Task-file map, indexed by chip select and address.
  localparam logic [4:0] REG_DATA    = 5'h10;
  localparam logic [4:0] REG_SCOUNT  = 5'h12;
  localparam logic [4:0] REG_SNUM    = 5'h13;
  localparam logic [4:0] REG_CYLLO   = 5'h14;
  localparam logic [4:0] REG_CYLHI   = 5'h15;
  localparam logic [4:0] REG_DRVHD   = 5'h16;
  localparam logic [4:0] REG_CMDSTAT = 5'h17;

  localparam logic [15:0] CMD_READ  = 16'h0020;
  localparam logic [15:0] CMD_WRITE = 16'h0030;

  localparam logic [7:0] ST_IDLE = 8'h50;
  localparam logic [7:0] ST_XFER = 8'h58;

  typedef struct packed {
    op_e         opcode;
    logic        dior_n;
    logic        diow_n;
    logic [1:0]  chip_select;
    logic [2:0]  reg_address;
    logic [15:0] data_in;
    logic [11:0] buffer_index;
  } item_t;

  // Everything the result stage needs about one transaction, taken after
  // the task file has been updated.
  typedef struct packed {
    op_e         opcode;
    lrv_e        lrv_sel;
    logic        rd_ok;
    logic        fwd;
    logic [15:0] fwd_data;
    logic        drive;
    logic        rreq;
    logic        freq;
    logic [27:0] lba;
    logic [4:0]  sectors;
    logic [7:0]  status;
  } snap_t;

  typedef struct packed {
    logic [15:0] host_data;
    logic        data_drive;
    logic        storage_read_request;
    logic        storage_flush_request;
    logic [27:0] request_lba;
    logic [4:0]  request_sectors;
    logic [7:0]  status_bits;
  } res_t;

endpackage

`default_nettype wire

// ===== design/apdt_buffer.sv =====
// ----------------------------------------------------------------------------
// Sector buffer
// Single-port-write, single-port-read synchronous RAM with registered read
// data. A read and a write in the same cycle return the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module apdt_buffer #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Aw    = 12
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [Aw-1:0] waddr_i,
  input  wire logic [15:0]   wdata_i,
  input  wire logic          re_i,
  input  wire logic [Aw-1:0] raddr_i,
  output      logic [15:0]   rdata_o
);

  logic [15:0] mem [Depth];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/apdt_taskfile.sv =====
// ----------------------------------------------------------------------------
// Task file and transfer control
// Detects strobe edges, decodes register and command accesses, keeps the
// LBA registers, transfer pointers and status, and issues buffer accesses.
// ----------------------------------------------------------------------------
`default_nettype none

module apdt_taskfile
  import apdt_pkg::*;
#(
  parameter int unsigned BUF_WORDS = 4096,
  parameter int unsigned Aw        = 12
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire item_t         item_i,
  output      logic          mem_we_o,
  output      logic [Aw-1:0] mem_waddr_o,
  output      logic [15:0]   mem_wdata_o,
  output      logic          mem_re_o,
  output      logic [Aw-1:0] mem_raddr_o,
  output      snap_t         snap_o
);

  localparam int unsigned Cap = BUF_WORDS / 256;
  localparam int unsigned Cw  = $clog2(Cap + 1);
  localparam int unsigned Pw  = $clog2(BUF_WORDS + 1);
  localparam logic [Pw-1:0] BufEnd = Pw'(BUF_WORDS);

  function automatic logic [Cw-1:0] sat_f(input logic [15:0] n);
    logic [Cw-1:0] r;
    if (n > 16'(Cap)) r = Cw'(Cap);
    else              r = Cw'(n);
    return r;
  endfunction

  logic          prev_rd_q, prev_rd_d;
  logic          prev_wr_q, prev_wr_d;
  logic [15:0]   sc_q, sc_d;
  logic [7:0]    sn_q, sn_d;
  logic [7:0]    cl_q, cl_d;
  logic [7:0]    ch_q, ch_d;
  logic [3:0]    dh_q, dh_d;
  logic [27:0]   lba_q, lba_d;
  logic [7:0]    st_q, st_d;
  logic [Pw-1:0] rp_q, rp_d;
  logic [Pw-1:0] wp_q, wp_d;
  logic [Pw-1:0] tw_q, tw_d;

  logic [4:0]    tf_addr;
  logic          rd_start;
  logic          wr_start;
  logic          idx_ok;
  logic [Pw-1:0] ptr_next;
  logic          rd_ok;
  lrv_e          lrv_sel;
  logic          rreq;
  logic          freq;

  assign tf_addr  = {item_i.chip_select, item_i.reg_address};
  assign rd_start = prev_rd_q & ~item_i.dior_n;
  assign wr_start = prev_wr_q & ~item_i.diow_n;
  assign idx_ok   = 32'(item_i.buffer_index) < 32'(BUF_WORDS);

  always_comb begin
    prev_rd_d   = prev_rd_q;
    prev_wr_d   = prev_wr_q;
    sc_d        = sc_q;
    sn_d        = sn_q;
    cl_d        = cl_q;
    ch_d        = ch_q;
    dh_d        = dh_q;
    lba_d       = lba_q;
    st_d        = st_q;
    rp_d        = rp_q;
    wp_d        = wp_q;
    tw_d        = tw_q;
    ptr_next    = wp_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = Aw'(item_i.buffer_index);
    mem_wdata_o = item_i.data_in;
    mem_re_o    = 1'b0;
    mem_raddr_o = Aw'(item_i.buffer_index);
    rd_ok       = 1'b0;
    lrv_sel     = LRV_KEEP;
    rreq        = 1'b0;
    freq        = 1'b0;

    case (item_i.opcode)
      OP_BUS: begin
        prev_rd_d = item_i.dior_n;
        prev_wr_d = item_i.diow_n;

        // The write side is handled before the read side of the same sample.
        if (wr_start) begin
          case (tf_addr)
            REG_SCOUNT: sc_d = item_i.data_in;
            REG_SNUM:   sn_d = item_i.data_in[7:0];
            REG_CYLLO:  cl_d = item_i.data_in[7:0];
            REG_CYLHI:  ch_d = item_i.data_in[7:0];
            REG_DRVHD:  dh_d = item_i.data_in[3:0];
            REG_DATA: begin
              if (wp_q < BufEnd) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = Aw'(wp_q);
              end
              ptr_next = (wp_q < tw_q) ? wp_q + Pw'(1) : wp_q;
              wp_d     = ptr_next;
              if (ptr_next >= tw_q) begin
                freq = 1'b1;
                st_d = ST_IDLE;
              end
            end
            REG_CMDSTAT: begin
              if (item_i.data_in == CMD_READ || item_i.data_in == CMD_WRITE) begin
                lba_d = {dh_q, ch_q, cl_q, sn_q};
                tw_d  = Pw'({sat_f(sc_q), 8'h00});
                rp_d  = '0;
                wp_d  = '0;
                st_d  = ST_XFER;
                rreq  = (item_i.data_in == CMD_READ);
              end
            end
            // Control register writes and unmapped accesses are ignored.
            default: ;
          endcase
        end

        if (rd_start) begin
          if (tf_addr == REG_DATA) begin
            rd_ok       = rp_q < BufEnd;
            mem_re_o    = rd_ok;
            mem_raddr_o = Aw'(rp_q);
            lrv_sel     = LRV_MEM;
            rp_d        = (rp_q < tw_q) ? rp_q + Pw'(1) : rp_q;
            if (rp_d >= tw_q) begin
              st_d = ST_IDLE;
            end
          end else if (tf_addr == REG_CMDSTAT) begin
            lrv_sel = LRV_STATUS;
          end
        end
      end
      OP_FILL: begin
        mem_we_o = idx_ok;
      end
      OP_DRAIN: begin
        rd_ok    = idx_ok;
        mem_re_o = idx_ok;
      end
      default: ;
    endcase
  end

  always_comb begin
    snap_o          = '0;
    snap_o.opcode   = item_i.opcode;
    snap_o.lrv_sel  = lrv_sel;
    snap_o.rd_ok    = rd_ok;
    // A data write and a data read of the same word in one sample: the
    // read must see the new word, which the RAM does not return yet.
    snap_o.fwd      = mem_we_o & mem_re_o & (mem_waddr_o == mem_raddr_o);
    snap_o.fwd_data = item_i.data_in;
    snap_o.drive    = (item_i.opcode == OP_BUS) & ~item_i.dior_n;
    snap_o.rreq     = rreq;
    snap_o.freq     = freq;
    snap_o.lba      = lba_d;
    snap_o.sectors  = 5'(sat_f(sc_d));
    snap_o.status   = st_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_rd_q <= 1'b0;
      prev_wr_q <= 1'b0;
      sc_q      <= '0;
      sn_q      <= '0;
      cl_q      <= '0;
      ch_q      <= '0;
      dh_q      <= '0;
      lba_q     <= '0;
      st_q      <= ST_IDLE;
      rp_q      <= '0;
      wp_q      <= '0;
      tw_q      <= '0;
    end else if (accept_i) begin
      prev_rd_q <= prev_rd_d;
      prev_wr_q <= prev_wr_d;
      sc_q      <= sc_d;
      sn_q      <= sn_d;
      cl_q      <= cl_d;
      ch_q      <= ch_d;
      dh_q      <= dh_d;
      lba_q     <= lba_d;
      st_q      <= st_d;
      rp_q      <= rp_d;
      wp_q      <= wp_d;
      tw_q      <= tw_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/ata_pio_drive_target_unit.sv =====
// ----------------------------------------------------------------------------
// ATA PIO drive target
// Pipeline: an accepted transaction is registered with the sector buffer read,
// then in the output register. Throughput: one transaction per cycle unless
// the output stalls; the buffer has one write and one read port, and a
// same-word write and read in one sample are forwarded.
// Reset: task file, pointers and strobe history clear, status reads 0x50;
// the sector buffer is not cleared and holds undefined data until written.
// ----------------------------------------------------------------------------
`default_nettype none

module ata_pio_drive_target_unit
  import apdt_pkg::*;
#(
  parameter int unsigned BUF_WORDS = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // dior_n, diow_n, chip_select[1:0], reg_address[2:0], data_in[15:0],
  // buffer_index[11:0], zero fill
  input  wire logic [39:0] s_axis_tdata,
  // opcode[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // host_data[15:0], data_drive, storage_read_request, storage_flush_request,
  // request_lba[27:0], request_sectors[4:0], status_bits[7:0], zero fill
  output      logic [63:0] m_axis_tdata
);

  localparam int unsigned Aw = $clog2(BUF_WORDS);

  item_t         item;
  logic          accept;
  logic          s1_adv;
  logic          mem_we;
  logic [Aw-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [Aw-1:0] mem_raddr;
  logic [15:0]   mem_rdata;
  snap_t         snap;

  logic          s1_v_q, s1_v_d;
  snap_t         s1_q;
  logic          out_v_q, out_v_d;
  res_t          out_q;
  logic [15:0]   lrv_q;

  logic [15:0]   rd_word;
  logic [15:0]   lrv_new;
  res_t          res;

  assign item.opcode       = op_e'(s_axis_tuser);
  assign item.dior_n       = s_axis_tdata[0];
  assign item.diow_n       = s_axis_tdata[1];
  assign item.chip_select  = s_axis_tdata[3:2];
  assign item.reg_address  = s_axis_tdata[6:4];
  assign item.data_in      = s_axis_tdata[22:7];
  assign item.buffer_index = s_axis_tdata[34:23];

  // The buffer stage may take a new transaction while a finished result waits.
  assign s1_adv        = s1_v_q & (~out_v_q | m_axis_tready);
  assign s_axis_tready = ~s1_v_q | s1_adv;
  assign accept        = s_axis_tvalid & s_axis_tready;

  apdt_taskfile #(
    .BUF_WORDS (BUF_WORDS),
    .Aw        (Aw)
  ) u_taskfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (item),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .snap_o      (snap)
  );

  apdt_buffer #(
    .Depth (BUF_WORDS),
    .Aw    (Aw)
  ) u_buffer (
    .clk_i   (clk_i),
    .we_i    (mem_we & accept),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re & accept),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    rd_word = '0;
    if (s1_q.rd_ok) begin
      rd_word = s1_q.fwd ? s1_q.fwd_data : mem_rdata;
    end

    case (s1_q.lrv_sel)
      LRV_MEM:    lrv_new = rd_word;
      LRV_STATUS: lrv_new = {8'h00, s1_q.status};
      default:    lrv_new = lrv_q;
    endcase

    res                       = '0;
    res.data_drive            = s1_q.drive;
    res.storage_read_request  = s1_q.rreq;
    res.storage_flush_request = s1_q.freq;
    res.request_lba           = s1_q.lba;
    res.request_sectors       = s1_q.sectors;
    res.status_bits           = s1_q.status;
    case (s1_q.opcode)
      OP_BUS:   res.host_data = lrv_new;
      OP_DRAIN: res.host_data = rd_word;
      default:  res.host_data = '0;
    endcase
  end

  assign s1_v_d  = accept | (s1_v_q & ~s1_adv);
  assign out_v_d = s1_adv | (out_v_q & ~m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      lrv_q   <= '0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
      // The host read value advances in transaction order, as results leave
      // the buffer stage.
      if (s1_adv && s1_q.opcode == OP_BUS) begin
        lrv_q <= lrv_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= snap;
    end
    if (s1_adv) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {4'h0, out_q.status_bits, out_q.request_sectors,
                          out_q.request_lba, out_q.storage_flush_request,
                          out_q.storage_read_request, out_q.data_drive,
                          out_q.host_data};

  a_req_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> !(out_q.storage_read_request && out_q.storage_flush_request))
    else $error("read and flush requests raised by one transaction");

  a_read_opens_xfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.storage_read_request) |-> (out_q.status_bits == ST_XFER))
    else $error("read request without a transfer in progress");

  a_stage_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !out_v_q) |=> out_v_q)
    else $error("buffer stage result not moved to an empty output register");

  a_fwd_is_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && s1_q.fwd) |-> (s1_q.opcode == OP_BUS && s1_q.lrv_sel == LRV_MEM))
    else $error("forwarded word on a transaction without a data read");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// ATA PIO drive target testbench
// Drives bus samples, fill and drain transactions into the unit and checks
// every result word against a cycle-free model of the task file, the sector
// buffer and the status register kept inside this module.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
  import apdt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BUF_WORDS      = 4096;
  localparam int unsigned SECTOR_WORDS   = 256;
  localparam int unsigned MAX_SECTORS    = BUF_WORDS / SECTOR_WORDS;
  localparam int unsigned RANDOM_ITEMS   = 760;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 8;

  // Control register addresses: writes are accepted and have no effect.
  localparam logic [4:0] REG_CTL_LO = 5'h0E;
  localparam logic [4:0] REG_CTL_HI = 5'h1E;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // dior_n, diow_n, chip_select[1:0], reg_address[2:0], data_in[15:0],
  // buffer_index[11:0], zero fill
  logic [39:0] s_axis_tdata  = '0;
  // opcode[1:0]
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // host_data[15:0], data_drive, storage_read_request, storage_flush_request,
  // request_lba[27:0], request_sectors[4:0], status_bits[7:0], zero fill
  logic [63:0] m_axis_tdata;

  ata_pio_drive_target_unit #(
    .BUF_WORDS(BUF_WORDS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Drive state as the host and the storage side see it after every
  // accepted transaction.
  logic        prev_dior   = 1'b0;
  logic        prev_diow   = 1'b0;
  logic [15:0] tf_seccnt   = '0;
  logic [7:0]  tf_secnum   = '0;
  logic [7:0]  tf_cyllo    = '0;
  logic [7:0]  tf_cylhi    = '0;
  logic [3:0]  tf_head     = '0;
  logic [27:0] cur_lba     = '0;
  logic [7:0]  cur_status  = ST_IDLE;
  int unsigned rd_ptr      = 0;
  int unsigned wr_ptr      = 0;
  int unsigned xfer_words  = 0;
  logic [15:0] host_rd_val = '0;
  logic [15:0] sbuf [BUF_WORDS];
  bit          sbuf_valid [BUF_WORDS];

  res_t        pending_results [$];
  int unsigned mismatch_count = 0;
  int unsigned items_sent     = 0;
  int unsigned burst_left     = 0;
  bit          sender_pauses  = 1'b1;
  int unsigned quiet_cycles   = 0;

  function automatic logic [4:0] sat_sectors();
    return (32'(tf_seccnt) > MAX_SECTORS) ? 5'(MAX_SECTORS) : 5'(tf_seccnt);
  endfunction

  function automatic void open_transfer();
    cur_lba    = {tf_head, tf_cylhi, tf_cyllo, tf_secnum};
    xfer_words = 32'(sat_sectors()) * SECTOR_WORDS;
    rd_ptr     = 0;
    wr_ptr     = 0;
    cur_status = ST_XFER;
  endfunction

  // Advances the drive state by one transaction and returns its result.
  function automatic res_t predict_drive(input item_t it);
    res_t       r;
    logic [4:0] reg_sel;
    logic       rd_fall;
    logic       wr_fall;
    r       = '0;
    reg_sel = {it.chip_select, it.reg_address};
    case (it.opcode)
      OP_BUS: begin
        rd_fall   = prev_dior && !it.dior_n;
        wr_fall   = prev_diow && !it.diow_n;
        prev_dior = it.dior_n;
        prev_diow = it.diow_n;
        // The write side of a sample is applied before its read side.
        if (wr_fall) begin
          case (reg_sel)
            REG_SCOUNT: tf_seccnt = it.data_in;
            REG_SNUM:   tf_secnum = it.data_in[7:0];
            REG_CYLLO:  tf_cyllo  = it.data_in[7:0];
            REG_CYLHI:  tf_cylhi  = it.data_in[7:0];
            REG_DRVHD:  tf_head   = it.data_in[3:0];
            REG_DATA: begin
              if (wr_ptr < BUF_WORDS) begin
                sbuf[12'(wr_ptr)]       = it.data_in;
                sbuf_valid[12'(wr_ptr)] = 1'b1;
              end
              if (wr_ptr < xfer_words) wr_ptr++;
              if (wr_ptr >= xfer_words) begin
                r.storage_flush_request = 1'b1;
                cur_status              = ST_IDLE;
              end
            end
            REG_CMDSTAT: begin
              if (it.data_in == CMD_READ) begin
                open_transfer();
                r.storage_read_request = 1'b1;
              end else if (it.data_in == CMD_WRITE) begin
                open_transfer();
              end
            end
            default: ;
          endcase
        end
        if (rd_fall) begin
          if (reg_sel == REG_DATA) begin
            host_rd_val = (rd_ptr < BUF_WORDS) ? sbuf[12'(rd_ptr)] : 16'h0000;
            if (rd_ptr < xfer_words) rd_ptr++;
            if (rd_ptr >= xfer_words) cur_status = ST_IDLE;
          end else if (reg_sel == REG_CMDSTAT) begin
            host_rd_val = {8'h00, cur_status};
          end
        end
        r.host_data  = host_rd_val;
        r.data_drive = !it.dior_n;
      end
      OP_FILL: begin
        sbuf[it.buffer_index]       = it.data_in;
        sbuf_valid[it.buffer_index] = 1'b1;
      end
      OP_DRAIN: r.host_data = sbuf[it.buffer_index];
      default: ;
    endcase
    r.request_lba     = cur_lba;
    r.request_sectors = sat_sectors();
    r.status_bits     = cur_status;
    return r;
  endfunction

  // Buffer words that were never written hold no defined value, so any
  // transaction that would read one is bent into a harmless neighbor.
  function automatic item_t keep_reads_defined(input item_t it);
    item_t o;
    logic  wr_fall;
    o = it;
    if (it.opcode == OP_DRAIN && !sbuf_valid[it.buffer_index]) begin
      o.opcode = OP_FILL;
    end else if (it.opcode == OP_BUS && prev_dior && !it.dior_n &&
                 {it.chip_select, it.reg_address} == REG_DATA &&
                 rd_ptr < BUF_WORDS && !sbuf_valid[12'(rd_ptr)]) begin
      wr_fall = prev_diow && !it.diow_n;
      if (!(wr_fall && wr_ptr == rd_ptr)) o.dior_n = 1'b1;
    end
    return o;
  endfunction

  function automatic item_t make_item(input op_e op, input logic dior_n,
                                      input logic diow_n, input logic [4:0] reg_sel,
                                      input logic [15:0] value,
                                      input logic [11:0] index);
    item_t it;
    it.opcode       = op;
    it.dior_n       = dior_n;
    it.diow_n       = diow_n;
    it.chip_select  = reg_sel[4:3];
    it.reg_address  = reg_sel[2:0];
    it.data_in      = value;
    it.buffer_index = index;
    return it;
  endfunction

  task automatic send_item(input item_t raw);
    item_t it;
    it = keep_reads_defined(raw);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (sender_pauses) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.opcode;
    s_axis_tdata  <= {5'b0, it.buffer_index, it.data_in, it.reg_address,
                      it.chip_select, it.diow_n, it.dior_n};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_drive(it));
    items_sent++;
  endtask

  // One host register access: the strobe is raised first when it is still
  // low, so that the access sample carries a falling edge.
  task automatic host_access(input bit is_read, input logic [4:0] reg_sel,
                             input logic [15:0] value);
    if (is_read ? !prev_dior : !prev_diow) begin
      send_item(make_item(OP_BUS, 1'b1, 1'b1, 5'($urandom), 16'($urandom),
                          12'($urandom)));
    end
    send_item(make_item(OP_BUS, !is_read, is_read, reg_sel, value, 12'($urandom)));
  endtask

  function automatic logic [15:0] pick_count();
    case ($urandom_range(0, 9))
      0:             return 16'd0;
      1, 2, 3, 4, 5: return 16'($urandom_range(1, 2));
      6, 7:          return 16'($urandom_range(3, MAX_SECTORS));
      default:       return 16'($urandom);
    endcase
  endfunction

  task automatic load_task_file(input logic [15:0] count);
    host_access(1'b0, REG_SCOUNT, count);
    if ($urandom_range(0, 1)) host_access(1'b0, REG_SNUM, 16'($urandom));
    if ($urandom_range(0, 1)) host_access(1'b0, REG_CYLLO, 16'($urandom));
    if ($urandom_range(0, 1)) host_access(1'b0, REG_CYLHI, 16'($urandom));
    if ($urandom_range(0, 1)) host_access(1'b0, REG_DRVHD, 16'($urandom));
  endtask

  task automatic run_read_transfer();
    int unsigned words;
    int unsigned i;
    words = $urandom_range(1, 24);
    load_task_file(pick_count());
    host_access(1'b0, REG_CMDSTAT, CMD_READ);
    for (i = 0; i < words; i++) begin
      send_item(make_item(OP_FILL, 1'($urandom), 1'($urandom), 5'($urandom),
                          16'($urandom), 12'(i)));
    end
    repeat ($urandom_range(1, words + 4)) begin
      if ($urandom_range(0, 5) == 0) host_access(1'b1, REG_CMDSTAT, 16'($urandom));
      host_access(1'b1, REG_DATA, 16'($urandom));
    end
  endtask

  task automatic run_write_transfer();
    int unsigned words;
    words = $urandom_range(1, 24);
    load_task_file(pick_count());
    host_access(1'b0, REG_CMDSTAT, CMD_WRITE);
    repeat (words) begin
      if ($urandom_range(0, 5) == 0) host_access(1'b1, REG_CMDSTAT, 16'($urandom));
      host_access(1'b0, REG_DATA, 16'($urandom));
    end
    repeat ($urandom_range(1, 6)) begin
      send_item(make_item(OP_DRAIN, 1'($urandom), 1'($urandom), 5'($urandom),
                          16'($urandom), 12'($urandom_range(0, words - 1))));
    end
  endtask

  // Raw samples with arbitrary strobes, addresses and opcodes.
  task automatic run_noise();
    logic [4:0]  reg_sel;
    logic [15:0] value;
    repeat ($urandom_range(1, 8)) begin
      reg_sel = $urandom_range(0, 1) ? 5'($urandom_range(REG_DATA, REG_CMDSTAT))
                                     : 5'($urandom);
      value   = ($urandom_range(0, 3) == 0) ?
                ($urandom_range(0, 1) ? CMD_READ : CMD_WRITE) : 16'($urandom);
      send_item(make_item(op_e'(2'($urandom_range(0, 3))), 1'($urandom),
                          1'($urandom), reg_sel, value, 12'($urandom)));
    end
  endtask

  task automatic test_directed();
    // Strobes, address and data fields at their top values, on an address nothing decodes.
    send_item(make_item(OP_BUS, 1'b1, 1'b1, 5'h1F, 16'hFFFF, 12'hFFF));
    host_access(1'b1, REG_CMDSTAT, 16'h0000);
    host_access(1'b0, REG_CTL_LO, 16'hFFFF);
    host_access(1'b0, REG_CTL_HI, 16'h0000);
    // With no transfer open every data write asks for a flush.
    host_access(1'b0, REG_DATA, 16'hFFFF);
    host_access(1'b0, REG_CMDSTAT, 16'h0021);
    send_item(make_item(OP_FILL, 1'b0, 1'b0, 5'h00, 16'h0000, 12'hFFF));
    send_item(make_item(OP_DRAIN, 1'b1, 1'b1, 5'h1F, 16'hFFFF, 12'hFFF));
    send_item(make_item(OP_DRAIN, 1'b0, 1'b0, 5'h00, 16'h0000, 12'h000));
    send_item(make_item(OP_NOP, 1'b0, 1'b0, 5'h1F, 16'hFFFF, 12'hFFF));
    // Write and read edges of the data port in the same sample.
    send_item(make_item(OP_BUS, 1'b1, 1'b1, 5'h00, 16'h0000, 12'h000));
    send_item(make_item(OP_BUS, 1'b0, 1'b0, REG_DATA, 16'h5AA5, 12'h000));
    host_access(1'b0, REG_SCOUNT, 16'hFFFF);
    host_access(1'b0, REG_CMDSTAT, CMD_READ);
    send_item(make_item(OP_FILL, 1'b1, 1'b1, 5'h00, 16'h1234, 12'h000));
    host_access(1'b1, REG_DATA, 16'h0000);
    host_access(1'b0, REG_SCOUNT, 16'h0000);
    host_access(1'b0, REG_CMDSTAT, CMD_WRITE);
  endtask

  task automatic test_random_traffic();
    int unsigned stop_at;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      sender_pauses = ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2: run_read_transfer();
        3, 4, 5: run_write_transfer();
        default: run_noise();
      endcase
    end
    sender_pauses = 1'b1;
  endtask

  // The sector count is first loaded above the buffer size so that it
  // saturates, then a one-sector write and read transfer runs, each followed
  // by one more data access with the pointer parked at the transfer end.
  task automatic test_transfer_end();
    load_task_file(16'(MAX_SECTORS + 1));
    host_access(1'b0, REG_SCOUNT, 16'd1);
    host_access(1'b0, REG_CMDSTAT, CMD_WRITE);
    repeat (SECTOR_WORDS + 1) host_access(1'b0, REG_DATA, 16'($urandom));
    host_access(1'b1, REG_CMDSTAT, 16'($urandom));
    host_access(1'b0, REG_CMDSTAT, CMD_READ);
    repeat (SECTOR_WORDS + 1) host_access(1'b1, REG_DATA, 16'($urandom));
    host_access(1'b1, REG_CMDSTAT, 16'($urandom));
    repeat (8) begin
      send_item(make_item(OP_DRAIN, 1'($urandom), 1'($urandom), 5'($urandom),
                          16'($urandom), 12'($urandom)));
    end
  endtask

  // Receiver stall pattern, with a new mode picked at random after each run.
  initial begin : ready_pattern
    int unsigned mode;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 200)) begin
        @(negedge clk_i);
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          2:       m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing pending: 0x%h", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("host_data", 32'(want.host_data), 32'(m_axis_tdata[15:0]));
        check_field("data_drive", 32'(want.data_drive), 32'(m_axis_tdata[16]));
        check_field("storage_read_request", 32'(want.storage_read_request),
                    32'(m_axis_tdata[17]));
        check_field("storage_flush_request", 32'(want.storage_flush_request),
                    32'(m_axis_tdata[18]));
        check_field("request_lba", 32'(want.request_lba), 32'(m_axis_tdata[46:19]));
        check_field("request_sectors", 32'(want.request_sectors),
                    32'(m_axis_tdata[51:47]));
        check_field("status_bits", 32'(want.status_bits), 32'(m_axis_tdata[59:52]));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("ata_pio_drive_target_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_traffic();
    test_transfer_end();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("ata_pio_drive_target_unit regression: pass");
    end else begin
      $display("ata_pio_drive_target_unit regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
design/apdt_pkg.sv
design/apdt_buffer.sv
design/apdt_taskfile.sv
design/ata_pio_drive_target_unit.sv
test/tb_top.sv
